// File: hw/rtl/cdr_pkg.sv
// Shared constants, config register layout and saturation helper for the
// comb/delay reverberator. No dependencies.
package cdr_pkg;

  localparam int unsigned RING_DEPTH_DEF  = 16384;
  localparam int unsigned COMB_COUNT_DEF  = 4;
  localparam int unsigned DELAY_COUNT_DEF = 2;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAC_W     = 15;
  localparam int unsigned SAT_W      = 20;
  localparam int unsigned RING_LEN_W = 15;
  localparam int unsigned MIN_RING   = 1618;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  localparam int unsigned DELAY_W = 11;
  localparam logic [DELAY_W-1:0] COMB_DELAY [4] = '{11'd1557, 11'd1617, 11'd1491, 11'd1422};
  localparam logic [DELAY_W-1:0] LINE_DELAY [2] = '{11'd225, 11'd556};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_FB_GAIN   = 3'd1,
    REG_DRY_GAIN  = 3'd2,
    REG_WET_GAIN  = 3'd3,
    REG_RING_LEN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                  enable;
    logic [14:0]           feedback_gain;
    logic [15:0]           dry_gain;
    logic [15:0]           wet_gain;
    logic [RING_LEN_W-1:0] ring_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:        1'b0,
    feedback_gain: 15'd16384,
    dry_gain:      16'd16384,
    wet_gain:      16'd16384,
    ring_length:   15'd12000
  };

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] x);
    logic signed [SAMPLE_W-1:0] r;
    if (x > SAT_W'(32767)) begin
      r = 16'sh7fff;
    end else if (x < -SAT_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = x[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/cdr_in_if.sv
// Input sample channel: valid/ready handshake carrying one dry sample.
// Depends on cdr_pkg for the sample width.
interface cdr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cdr_pkg::SAMPLE_W-1:0]  in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

// File: hw/rtl/cdr_out_if.sv
// Output sample channel: valid/ready handshake carrying one mixed sample.
// Depends on cdr_pkg for the sample width.
interface cdr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cdr_pkg::SAMPLE_W-1:0]  mixed_sample;

  modport source (output valid, output mixed_sample, input ready);
  modport sink   (input valid, input mixed_sample, output ready);
endinterface

// File: hw/rtl/comb_delay_reverb.sv
// Top level of the comb/delay reverberator: config registers, front end,
// command queue and back end. Depends on cdr_pkg, cdr_in_if, cdr_out_if, submodules.
//
// Port     Dir  Payload                       Flow control
// in_i     in   in_sample    s16 Q15          valid/ready
// out_o    out  mixed_sample s16 Q15          valid/ready
// cfg      in   cfg_idx_i, cfg_data_i [15:0]  cfg_we_i, write only, no stall
//
// Every ring is a single-port memory, so reads issue only on even cycles and
// write-backs on odd ones; a new item can issue while earlier ones are in flight.
// Accepted items pass the command queue, ring read, pipeline stages and result buffer.
// After reset a clearing pass zeroes every entry of every ring (RING_DEPTH, 16384 by
// default); in_i.ready stays low meanwhile, config writes are taken.
// Up to 4 results wait at the output; beyond that the back end stops issuing
// and the 2-entry command queue fills before in_i.ready drops.
module comb_delay_reverb #(
  parameter int unsigned RING_DEPTH  = cdr_pkg::RING_DEPTH_DEF,
  parameter int unsigned COMB_COUNT  = cdr_pkg::COMB_COUNT_DEF,
  parameter int unsigned DELAY_COUNT = cdr_pkg::DELAY_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cdr_in_if.sink                           in_i,
  cdr_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [cdr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cdr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import cdr_pkg::*;

  localparam int unsigned AW    = $clog2(RING_DEPTH);
  localparam int unsigned LW    = $clog2(RING_DEPTH + 1);
  localparam int unsigned LEN_W = (LW > RING_LEN_W) ? LW : RING_LEN_W;
  localparam int unsigned CMD_W = 1 + SAMPLE_W + AW;

  cfg_t              cfg_q, cfg_d;
  logic [LEN_W-1:0]  len_raw;
  logic [LW-1:0]     ring_len;

  logic              in_ready;
  logic              clr_busy;
  logic              cmd_valid, cmd_ready;
  logic [CMD_W-1:0]  cmd;
  logic              cq_valid, cq_ready;
  logic [CMD_W-1:0]  cq_data;
  logic              res_valid;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic              cmd_push, cmd_pop;
  logic [LW-1:0]     cmd_wp;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE:   cfg_d.enable        = cfg_data_i[0];
        REG_FB_GAIN:  cfg_d.feedback_gain = cfg_data_i[14:0];
        REG_DRY_GAIN: cfg_d.dry_gain      = cfg_data_i;
        REG_WET_GAIN: cfg_d.wet_gain      = cfg_data_i;
        REG_RING_LEN: cfg_d.ring_length   = cfg_data_i[RING_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // clamp the ring length between the longest delay plus one and the memory depth
  always_comb begin
    len_raw = LEN_W'(cfg_q.ring_length);
    if (len_raw < LEN_W'(MIN_RING)) begin
      ring_len = LW'(MIN_RING);
    end else if (len_raw > LEN_W'(RING_DEPTH)) begin
      ring_len = LW'(RING_DEPTH);
    end else begin
      ring_len = len_raw[LW-1:0];
    end
  end

  cdr_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (cfg_q.enable),
    .ring_len_i   (ring_len),
    .busy_i       (clr_busy),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_ready),
    .in_sample_i  (in_i.in_sample),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  cdr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_valid),
    .in_ready_o  (cmd_ready),
    .in_data_i   (cmd),
    .out_valid_o (cq_valid),
    .out_ready_i (cq_ready),
    .out_data_o  (cq_data)
  );

  cdr_back #(
    .RING_DEPTH  (RING_DEPTH),
    .COMB_COUNT  (COMB_COUNT),
    .DELAY_COUNT (DELAY_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ring_len_i   (ring_len),
    .cmd_valid_i  (cq_valid),
    .cmd_ready_o  (cq_ready),
    .cmd_i        (cq_data),
    .busy_o       (clr_busy),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready),
    .res_sample_o (res_sample)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = res_valid;
  assign out_o.mixed_sample = res_sample;

  assign cmd_push = cmd_valid && cmd_ready;
  assign cmd_pop  = cq_valid && cq_ready;
  assign cmd_wp   = LW'(cmd[AW-1:0]);

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !(in_i.valid && in_i.ready))
    else $error("item accepted during ring clearing pass");

  a_cmd_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (cmd_wp < ring_len))
    else $error("command write pointer outside ring length");

  a_issue_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !cmd_pop)
    else $error("back end issued on two consecutive cycles");

endmodule

// File: hw/rtl/cdr_queue.sv
// Small register FIFO with valid/ready on both sides.
// Used for the command queue and the result buffer; no package needed.
module cdr_queue #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  always_comb begin
    in_ready_o  = (cnt_q != CW'(DEPTH));
    out_valid_o = (cnt_q != '0);
    out_data_o  = mem_q[rd_ptr_q];
    push        = in_valid_i && in_ready_o;
    pop         = out_valid_o && out_ready_i;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// File: hw/rtl/cdr_front.sv
// Front end: accepts samples, marks them as bypass or reverb, owns the
// shared ring write pointer and pushes commands. Depends on cdr_pkg.
module cdr_front #(
  parameter  int unsigned RING_DEPTH = cdr_pkg::RING_DEPTH_DEF,
  localparam int unsigned AW         = $clog2(RING_DEPTH),
  localparam int unsigned LW         = $clog2(RING_DEPTH + 1),
  localparam int unsigned CMD_W      = 1 + cdr_pkg::SAMPLE_W + AW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                enable_i,
  input  logic [LW-1:0]                       ring_len_i,
  input  logic                                busy_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cdr_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output logic [CMD_W-1:0]                    cmd_o
);

  import cdr_pkg::*;

  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] wp_eff;
  logic [LW-1:0] wp_inc;
  logic          accept;

  always_comb begin
    // a pointer left beyond a shortened ring restarts at zero
    wp_eff      = (LW'(wp_q) >= ring_len_i) ? '0 : wp_q;
    wp_inc      = LW'(wp_eff) + LW'(1);
    in_ready_o  = cmd_ready_i && !busy_i;
    cmd_valid_o = in_valid_i && !busy_i;
    cmd_o       = {!enable_i, in_sample_i, wp_eff};
    accept      = in_valid_i && in_ready_o;
    wp_d        = wp_q;
    // advance only when the item touches the rings
    if (accept && enable_i) begin
      wp_d = (wp_inc >= ring_len_i) ? '0 : wp_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else begin
      wp_q <= wp_d;
    end
  end

endmodule

// File: hw/rtl/cdr_back.sv
// Back end: ring memories, comb feedback, delay chain and output mix,
// plus the post-reset clearing pass and result buffer. Depends on cdr_pkg, cdr_queue.
module cdr_back #(
  parameter  int unsigned RING_DEPTH  = cdr_pkg::RING_DEPTH_DEF,
  parameter  int unsigned COMB_COUNT  = cdr_pkg::COMB_COUNT_DEF,
  parameter  int unsigned DELAY_COUNT = cdr_pkg::DELAY_COUNT_DEF,
  localparam int unsigned AW          = $clog2(RING_DEPTH),
  localparam int unsigned LW          = $clog2(RING_DEPTH + 1),
  localparam int unsigned CMD_W       = 1 + cdr_pkg::SAMPLE_W + AW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cdr_pkg::cfg_t                       cfg_i,
  input  logic [LW-1:0]                       ring_len_i,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  logic [CMD_W-1:0]                    cmd_i,
  output logic                                busy_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic signed [cdr_pkg::SAMPLE_W-1:0] res_sample_o
);

  import cdr_pkg::*;

  localparam int unsigned OCC_W  = $clog2(RES_DEPTH + 1);
  localparam int unsigned PROD_W = 2 * SAMPLE_W;
  localparam int unsigned MIX_W  = 2 * SAMPLE_W + 1;
  localparam int unsigned SUM_W  = MIX_W + 1;

  // control
  logic             phase_q;
  logic             clr_busy_q, clr_busy_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic             issue, pop;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;

  // command fields
  logic                       cmd_bypass;
  logic signed [SAMPLE_W-1:0] cmd_dry;
  logic [AW-1:0]              cmd_wp;

  // ring read data
  logic [SAMPLE_W-1:0] comb_rd_q  [COMB_COUNT];
  logic [SAMPLE_W-1:0] delay_rd_q [DELAY_COUNT];

  // stage 1
  logic                       s1_valid_q, s1_bypass_q;
  logic signed [SAMPLE_W-1:0] s1_dry_q;
  logic [AW-1:0]              s1_wp_q;

  // stage 2
  logic                       s2_valid_q, s2_bypass_q;
  logic signed [SAMPLE_W-1:0] s2_dry_q;
  logic [AW-1:0]              s2_wp_q;
  logic signed [PROD_W-1:0]   s2_prod_q [COMB_COUNT];
  logic signed [PROD_W-1:0]   s2_prod_d [COMB_COUNT];
  logic [SAMPLE_W-1:0]        s2_dwr_q  [DELAY_COUNT];
  logic [SAMPLE_W-1:0]        s2_dwr_d  [DELAY_COUNT];
  logic signed [SAMPLE_W-1:0] s2_wet_q, s2_wet_d;
  logic [SAMPLE_W-1:0]        comb_sum;
  logic signed [SAMPLE_W-1:0] fb_gain;

  // stage 3
  logic                       s3_valid_q, s3_bypass_q;
  logic signed [SAMPLE_W-1:0] s3_dry_q;
  logic [AW-1:0]              s3_wp_q;
  logic signed [SAMPLE_W-1:0] s3_cwr_q [COMB_COUNT];
  logic signed [SAMPLE_W-1:0] s3_cwr_d [COMB_COUNT];
  logic [SAMPLE_W-1:0]        s3_dwr_q [DELAY_COUNT];
  logic signed [MIX_W-1:0]    s3_mixd_q, s3_mixd_d;
  logic signed [MIX_W-1:0]    s3_mixw_q, s3_mixw_d;

  // result
  logic signed [SUM_W-1:0]    mix_sum;
  logic signed [SAMPLE_W-1:0] res_d;

  always_comb begin
    cmd_bypass = cmd_i[CMD_W-1];
    cmd_dry    = cmd_i[AW +: SAMPLE_W];
    cmd_wp     = cmd_i[AW-1:0];
    // reads go out on even cycles; writes land from stage 3, on odd ones
    issue      = cmd_valid_i && !phase_q && !clr_busy_q && (occ_q < OCC_W'(RES_DEPTH));
    cmd_ready_o = issue;
    busy_o     = clr_busy_q;
    pop        = res_valid_o && res_ready_i;
    occ_d      = occ_q + OCC_W'(issue) - OCC_W'(pop);
    ram_we     = clr_busy_q || (s3_valid_q && !s3_bypass_q);
    ram_waddr  = clr_busy_q ? clr_cnt_q : s3_wp_q;
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(RING_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      occ_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      phase_q    <= !phase_q;
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
      occ_q      <= occ_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // ring memories: one port each, read on issue, written from stage 3 or by the clear
  for (genvar c = 0; c < COMB_COUNT; c++) begin : g_comb
    localparam logic [LW-1:0] DLY = LW'(COMB_DELAY[c % 4]);
    logic [SAMPLE_W-1:0] mem [RING_DEPTH];
    logic [LW-1:0]       rp_full;
    logic [AW-1:0]       addr;

    always_comb begin
      rp_full = (LW'(cmd_wp) >= DLY) ? LW'(cmd_wp) - DLY : LW'(cmd_wp) + ring_len_i - DLY;
      addr    = ram_we ? ram_waddr : rp_full[AW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (ram_we) begin
        mem[addr] <= clr_busy_q ? '0 : s3_cwr_q[c];
      end else if (issue) begin
        comb_rd_q[c] <= mem[addr];
      end
    end
  end

  for (genvar a = 0; a < DELAY_COUNT; a++) begin : g_line
    localparam logic [LW-1:0] DLY = LW'(LINE_DELAY[a % 2]);
    logic [SAMPLE_W-1:0] mem [RING_DEPTH];
    logic [LW-1:0]       rp_full;
    logic [AW-1:0]       addr;

    always_comb begin
      rp_full = (LW'(cmd_wp) >= DLY) ? LW'(cmd_wp) - DLY : LW'(cmd_wp) + ring_len_i - DLY;
      addr    = ram_we ? ram_waddr : rp_full[AW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (ram_we) begin
        mem[addr] <= clr_busy_q ? '0 : s3_dwr_q[a];
      end else if (issue) begin
        delay_rd_q[a] <= mem[addr];
      end
    end
  end

  // stage 1: feedback products, comb sum, delay chain shift
  always_comb begin
    fb_gain  = $signed({1'b0, cfg_i.feedback_gain});
    comb_sum = '0;
    for (int c = 0; c < COMB_COUNT; c++) begin
      comb_sum     = comb_sum + comb_rd_q[c];
      s2_prod_d[c] = $signed(comb_rd_q[c]) * fb_gain;
    end
    s2_dwr_d[0] = comb_sum;
    for (int a = 1; a < DELAY_COUNT; a++) begin
      s2_dwr_d[a] = delay_rd_q[a-1];
    end
    s2_wet_d = $signed(delay_rd_q[DELAY_COUNT-1]);
  end

  // stage 2: comb write-back values and mix products
  always_comb begin
    logic signed [PROD_W-FRAC_W-1:0] fb;
    for (int c = 0; c < COMB_COUNT; c++) begin
      fb          = $signed(s2_prod_q[c][PROD_W-1:FRAC_W]);
      s3_cwr_d[c] = sat_sample(SAT_W'(s2_dry_q) + SAT_W'(fb));
    end
    s3_mixd_d = s2_dry_q * $signed({1'b0, cfg_i.dry_gain});
    s3_mixw_d = s2_wet_q * $signed({1'b0, cfg_i.wet_gain});
  end

  // stage 3: final mix
  always_comb begin
    mix_sum = SUM_W'(s3_mixd_q) + SUM_W'(s3_mixw_q);
    res_d   = s3_bypass_q ? s3_dry_q
                          : sat_sample(SAT_W'($signed(mix_sum[SUM_W-1:FRAC_W])));
  end

  always_ff @(posedge clk_i) begin
    s1_bypass_q <= cmd_bypass;
    s1_dry_q    <= cmd_dry;
    s1_wp_q     <= cmd_wp;
    s2_bypass_q <= s1_bypass_q;
    s2_dry_q    <= s1_dry_q;
    s2_wp_q     <= s1_wp_q;
    s2_prod_q   <= s2_prod_d;
    s2_dwr_q    <= s2_dwr_d;
    s2_wet_q    <= s2_wet_d;
    s3_bypass_q <= s2_bypass_q;
    s3_dry_q    <= s2_dry_q;
    s3_wp_q     <= s2_wp_q;
    s3_cwr_q    <= s3_cwr_d;
    s3_dwr_q    <= s2_dwr_q;
    s3_mixd_q   <= s3_mixd_d;
    s3_mixw_q   <= s3_mixw_d;
  end

  // credits on issue guarantee room, so the buffer never refuses a push
  cdr_queue #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RES_DEPTH)
  ) u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_valid_q),
    .in_ready_o  (),
    .in_data_i   (res_d),
    .out_valid_o (res_valid_o),
    .out_ready_i (res_ready_i),
    .out_data_o  (res_sample_o)
  );

endmodule

// File: bench/testbench.sv
// Self-checking bench for comb_delay_reverb: random Q15 samples with random idling,
// checked against a bit-exact comb/delay reverb predictor across register settings.
// Depends on cdr_pkg, cdr_in_if, cdr_out_if and the comb_delay_reverb RTL.
module testbench;
  import cdr_pkg::*;

  localparam int RING_MIN_LEN = 1618;
  localparam int RING_MAX_LEN = 16384;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int QUIET_LIMIT  = 80000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bench-side drivers, known from time zero
  logic        drv_valid  = 1'b0;
  logic [15:0] drv_sample = '0;
  logic        rcv_ready  = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_idx    = '0;
  logic [15:0] cfg_data   = '0;

  cdr_in_if  in_if ();
  cdr_out_if out_if ();

  assign in_if.valid     = drv_valid;
  assign in_if.in_sample = drv_sample;
  assign out_if.ready    = rcv_ready;

  comb_delay_reverb i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state and register copies
  bit [15:0]   comb_ring  [4][RING_MAX_LEN];
  bit [15:0]   delay_ring [2][RING_MAX_LEN];
  int          wr_ptr = 0;
  int          comb_taps [4] = '{1557, 1617, 1491, 1422};
  int          line_taps [2] = '{225, 556};
  logic        r_enable   = 1'b0;
  logic [14:0] r_fb_gain  = 15'd16384;
  logic [15:0] r_dry_gain = 16'd16384;
  logic [15:0] r_wet_gain = 16'd16384;
  logic [14:0] r_ring_len = 15'd12000;

  logic [15:0] sample_q [$];
  logic [15:0] mix_q [$];
  logic [15:0] want_mix;

  int  n_accepted = 0;
  int  n_results  = 0;
  int  n_reverb   = 0;
  int  n_errors   = 0;
  int  n_settings = 0;
  int  quiet_cycles = 0;
  int  gap_left   = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  int  hold_reqs  = 0;
  int  hold_seen  = 0;
  bit  idle_on    = 1'b1;

  function automatic logic [15:0] clamp16(input longint x);
    logic [15:0] r;
    if (x > 32767) begin
      r = 16'h7fff;
    end else if (x < -32768) begin
      r = 16'h8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // Advance the reverb by one sample and return the mixed output; when disabled, return the dry sample.
  function automatic logic [15:0] reverb_sample(input logic [15:0] dry_bits);
    int          len, wp, rp;
    longint      dry, tap_out, fb, wet, mix;
    logic [15:0] comb_sum;
    dry = longint'($signed(dry_bits));
    if (!r_enable) begin
      return dry_bits;
    end
    n_reverb++;
    len = int'(r_ring_len);
    if (len < RING_MIN_LEN) begin
      len = RING_MIN_LEN;
    end
    if (len > RING_MAX_LEN) begin
      len = RING_MAX_LEN;
    end
    // a pointer left past a shrunken ring restarts at zero
    wp = (wr_ptr >= len) ? 0 : wr_ptr;
    comb_sum = '0;
    for (int c = 0; c < 4; c++) begin
      rp = (wp >= comb_taps[c]) ? wp - comb_taps[c] : wp + len - comb_taps[c];
      tap_out = longint'($signed(comb_ring[c][rp]));
      fb = (tap_out * longint'(r_fb_gain)) >>> 15;
      comb_ring[c][wp] = clamp16(dry + fb);
      comb_sum = comb_sum + tap_out[15:0];
    end
    wet = longint'($signed(comb_sum));
    for (int a = 0; a < 2; a++) begin
      rp = (wp >= line_taps[a]) ? wp - line_taps[a] : wp + len - line_taps[a];
      tap_out = longint'($signed(delay_ring[a][rp]));
      delay_ring[a][wp] = wet[15:0];
      wet = tap_out;
    end
    wp++;
    wr_ptr = (wp >= len) ? 0 : wp;
    mix = dry * longint'(r_dry_gain) + wet * longint'(r_wet_gain);
    return clamp16(mix >>> 15);
  endfunction

  // Driver: offer queued samples, predict each accepted item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        mix_q.push_back(reverb_sample(drv_sample));
        n_accepted++;
      end
      if (!drv_valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 17) - 1;
          drv_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          drv_valid  <= 1'b1;
          drv_sample <= sample_q.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_if.valid && rcv_ready) begin
        n_results++;
        if (mix_q.size() == 0) begin
          $error("mixed_sample %0d arrived with no sample pending",
                 $signed(out_if.mixed_sample));
          n_errors++;
        end else begin
          want_mix = mix_q.pop_front();
          if (out_if.mixed_sample !== want_mix) begin
            $error("mixed_sample: expected %0d, actual %0d",
                   $signed(want_mix), $signed(out_if.mixed_sample));
            n_errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        // long hold-off: let the block fill up and stall its input
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES - 1;
        rcv_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rcv_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((drv_valid && in_if.ready) || (out_if.valid && rcv_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $error("no item moved for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [15:0] pick_sample();
    int          kind;
    logic [15:0] s;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      s = 16'($urandom);
    end else if (kind < 70) begin
      s = 16'($signed($urandom_range(0, 512)) - 256);
    end else if (kind < 85) begin
      s = $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 63))
                               : 16'h8000 + 16'($urandom_range(0, 63));
    end else if (kind < 95) begin
      s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    end else begin
      s = '0;
    end
    return s;
  endfunction

  task automatic play(input int count);
    for (int i = 0; i < count; i++) begin
      sample_q.push_back(pick_sample());
    end
  endtask

  // Hold until every sample is in and every result is out.
  task automatic wait_idle();
    while (sample_q.size() != 0 || drv_valid || mix_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      REG_ENABLE:   r_enable   = value[0];
      REG_FB_GAIN:  r_fb_gain  = value[14:0];
      REG_DRY_GAIN: r_dry_gain = value;
      REG_WET_GAIN: r_wet_gain = value;
      REG_RING_LEN: r_ring_len = value[14:0];
      default: ;
    endcase
  endtask

  initial begin
    logic [15:0] bypass_set [7] = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001,
                                    16'hffff, 16'h5555, 16'haaaa};
    logic [15:0] edge_set [12] = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                   16'h0000, 16'hffff, 16'h0001, 16'h4000,
                                   16'hc000, 16'h5555, 16'haaaa, 16'h0000};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bypass after reset, offered while the rings are still clearing
    n_settings++;
    foreach (bypass_set[i]) sample_q.push_back(bypass_set[i]);
    wait_idle();

    write_reg(REG_ENABLE, 16'h0001);
    n_settings++;
    foreach (edge_set[i]) sample_q.push_back(edge_set[i]);
    play(350);
    while (sample_q.size() > 250) @(negedge clk_i);
    hold_reqs++;
    // keep offering items while the receiver holds off
    play(200);
    wait_idle();

    write_reg(REG_RING_LEN, 16'h0000);
    write_reg(REG_FB_GAIN, 16'hffff);
    write_reg(REG_DRY_GAIN, 16'hffff);
    write_reg(REG_WET_GAIN, 16'h8000);
    n_settings++;
    play(150);
    wait_idle();
    play(150);
    wait_idle();

    write_reg(REG_ENABLE, 16'h0000);
    n_settings++;
    play(30);
    wait_idle();

    write_reg(REG_ENABLE, 16'h0001);
    write_reg(REG_RING_LEN, 16'h7fff);
    write_reg(REG_FB_GAIN, 16'h0000);
    write_reg(REG_DRY_GAIN, 16'h0000);
    write_reg(REG_WET_GAIN, 16'h8000);
    n_settings++;
    play(80);
    wait_idle();

    write_reg(REG_RING_LEN, 16'd1618);
    write_reg(REG_FB_GAIN, 16'h0001);
    write_reg(REG_DRY_GAIN, 16'h8000);
    write_reg(REG_WET_GAIN, 16'h0000);
    n_settings++;
    hold_reqs++;
    play(100);
    wait_idle();

    // closing stretch at full rate
    idle_on = 1'b0;
    write_reg(REG_RING_LEN, 16'd5000);
    write_reg(REG_FB_GAIN, 16'd20000);
    write_reg(REG_DRY_GAIN, 16'd12345);
    write_reg(REG_WET_GAIN, 16'd40000);
    n_settings++;
    play(80);
    while (sample_q.size() != 0 || drv_valid || mix_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (12) @(negedge clk_i);

    $display("Checked %0d results for %0d samples, %0d of them through the reverb path.",
             n_results, n_accepted, n_reverb);
    $display("Register settings exercised: %0d, including bypass and out-of-range ring lengths.",
             n_settings);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/cdr_pkg.sv
hw/rtl/cdr_in_if.sv
hw/rtl/cdr_out_if.sv
hw/rtl/cdr_queue.sv
hw/rtl/cdr_front.sv
hw/rtl/cdr_back.sv
hw/rtl/comb_delay_reverb.sv
bench/testbench.sv
